// File: hdl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// shared types, constants and helpers of the potts wolff cluster update block
// ----------------------------------------------------------------------------
package pwc_pkg;

	localparam int unsigned SIDE_DEFAULT   = 128;
	localparam int unsigned STATES_DEFAULT = 4;

	localparam logic [31:0] THRESH_RESET = 32'd1883444531;
	localparam logic [31:0] SEED_RESET   = 32'd12345;

	localparam logic REG_ADD_THRESHOLD = 1'b0;
	localparam logic REG_RNG_SEED      = 1'b1;

	typedef struct packed {
		logic        func;
		logic [13:0] site;
		logic [1:0]  spin_value;
	} in_t;

	typedef struct packed {
		logic [14:0] cluster_size;
		logic [14:0] largest_count;
		logic [16:0] magnetization;
		logic        status;
	} out_t;

	typedef enum logic [1:0] {
		NB_ROW_NEXT,
		NB_ROW_PREV,
		NB_COL_NEXT,
		NB_COL_PREV
	} nb_dir_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_SITE,
		ST_DECIDE,
		ST_DIV_ROOT,
		ST_PUSH_ROOT,
		ST_POP,
		ST_CUR,
		ST_NB_RD,
		ST_NB_CHK,
		ST_MAX,
		ST_MAG,
		ST_MAG_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_take;
		logic clr_step;
		logic rd_site;
		logic wr_site;
		logic set_same;
		logic div_site;
		logic div_mag;
		logic push_root;
		logic pop;
		logic cur_take;
		logic rd_nb;
		logic nb_check;
		logic max_take;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_ok;
		logic func;
		logic same;
		logic div_busy;
		logic stack_empty;
		logic k_last;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] s);
		logic [31:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

// File: hdl/pwc_div.sv
// ----------------------------------------------------------------------------
// pwc_div
// divider by a constant, reciprocal multiplication eight numerator bits a cycle
// ----------------------------------------------------------------------------
module pwc_div #(
	parameter int unsigned NW  = 16,
	parameter int unsigned DEN = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	output logic          busy,
	output logic [NW-1:0] quot
);
	localparam int unsigned     CH    = 8;
	localparam int unsigned     NC    = (NW + CH - 1) / CH;
	localparam int unsigned     PW    = NC * CH;
	localparam int unsigned     LD    = $clog2(DEN);
	localparam int unsigned     SH    = NW + LD;
	localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam int unsigned     MB    = $clog2(RECIP + 1);
	localparam int unsigned     XW    = PW + MB;
	localparam int unsigned     CNTW  = $clog2(NC + 1);

	logic [CNTW-1:0] cnt_q;
	logic [PW-1:0]   num_q;
	logic [XW-1:0]   acc_q;
	logic [MB-1:0]   recip_v;
	logic [MB+CH-1:0] part;

	assign recip_v = MB'(RECIP);
	assign part    = recip_v * num_q[PW-1 -: CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(NC);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= PW'(num);
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= (acc_q << CH) + XW'(part);
			num_q <= num_q << CH;
		end
	end

	assign busy = cnt_q != '0;
	assign quot = NW'(acc_q >> SH);

endmodule

// File: hdl/pwc_ctrl.sv
// ----------------------------------------------------------------------------
// pwc_ctrl
// sequencer of loads, cluster growth and result generation
// ----------------------------------------------------------------------------
module pwc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pwc_pkg::stat_t stat,
	output pwc_pkg::cmd_t  cmd
);
	import pwc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_take = 1'b1;
					state_d     = ST_RD_SITE;
				end
			end
			ST_RD_SITE: begin
				if (stat.in_ok) begin
					cmd.rd_site = 1'b1;
					state_d     = ST_DECIDE;
				end else begin
					state_d = ST_MAX;
				end
			end
			ST_DECIDE: begin
				if (!stat.func) begin
					cmd.wr_site = 1'b1;
					state_d     = ST_MAX;
				end else if (stat.same) begin
					cmd.set_same = 1'b1;
					state_d      = ST_MAX;
				end else begin
					cmd.wr_site  = 1'b1;
					cmd.div_site = 1'b1;
					state_d      = ST_DIV_ROOT;
				end
			end
			ST_DIV_ROOT: begin
				if (!stat.div_busy) begin
					state_d = ST_PUSH_ROOT;
				end
			end
			ST_PUSH_ROOT: begin
				cmd.push_root = 1'b1;
				state_d       = ST_POP;
			end
			ST_POP: begin
				if (stat.stack_empty) begin
					state_d = ST_MAX;
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_CUR;
				end
			end
			ST_CUR: begin
				cmd.cur_take = 1'b1;
				state_d      = ST_NB_RD;
			end
			ST_NB_RD: begin
				cmd.rd_nb = 1'b1;
				state_d   = ST_NB_CHK;
			end
			ST_NB_CHK: begin
				cmd.nb_check = 1'b1;
				state_d      = stat.k_last ? ST_POP : ST_NB_RD;
			end
			ST_MAX: begin
				cmd.max_take = 1'b1;
				state_d      = ST_MAG;
			end
			ST_MAG: begin
				cmd.div_mag = 1'b1;
				state_d     = ST_MAG_WAIT;
			end
			ST_MAG_WAIT: begin
				if (!stat.div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_take |-> state_q == ST_IDLE)
		else $error("item taken outside idle");
	a_push_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_root |-> $past(state_q) == ST_DIV_ROOT && !stat.div_busy)
		else $error("root pushed before division done");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over pending result");
`endif

endmodule

// File: hdl/pwc_datapath.sv
// ----------------------------------------------------------------------------
// pwc_datapath
// spin store, site stack, state counts, generator, two dividers and result register
// ----------------------------------------------------------------------------
module pwc_datapath #(
	parameter int unsigned SIDE   = pwc_pkg::SIDE_DEFAULT,
	parameter int unsigned STATES = pwc_pkg::STATES_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pwc_pkg::in_t   in_data,
	input  logic           wr_en,
	input  logic           wr_index,
	input  logic [31:0]    wr_data,
	input  pwc_pkg::cmd_t  cmd,
	output pwc_pkg::stat_t stat,
	output logic           out_valid,
	input  logic           out_ready,
	output pwc_pkg::out_t  out_data
);
	import pwc_pkg::*;

	localparam int unsigned N   = SIDE * SIDE;
	localparam int unsigned AW  = $clog2(N);
	localparam int unsigned RW  = $clog2(SIDE);
	localparam int unsigned KW  = $clog2(N + 1);
	localparam int unsigned SW  = $clog2(STATES);
	localparam int unsigned VW  = KW + 3;
	localparam int unsigned DEN = (STATES - 1) * N;
	localparam int unsigned XB  = $clog2(DEN + 1);
	localparam int unsigned YB  = XB + 16;

	logic [SW-1:0]    spin_mem [N];
	logic [2*RW-1:0]  stack_mem [N];

	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    site_q;
	logic [SW-1:0]    nw_q;
	logic [SW-1:0]    old_q;
	logic             func_q;
	logic             ok_q;
	logic             status_q;
	logic [KW-1:0]    flipped_q;
	logic [KW-1:0]    top_q;
	logic [RW-1:0]    cur_row_q;
	logic [RW-1:0]    cur_col_q;
	nb_dir_t          k_q;
	logic [SW-1:0]    spin_rdata_q;
	logic [2*RW-1:0]  stack_rdata_q;
	logic [KW-1:0]    cnt_q [STATES];
	logic [KW-1:0]    largest_q;
	logic [31:0]      thresh_q;
	logic [31:0]      rng_q;
	logic             out_valid_q;
	out_t             out_q;

	logic [RW-1:0]    r_next, r_prev, c_next, c_prev, nrow, ncol;
	logic [AW-1:0]    nb_addr;
	logic [KW-1:0]    top_m1;
	logic [31:0]      rng_next;
	logic             nb_match, nb_join;
	logic             upd_en;
	logic [KW-1:0]    largest_d;
	logic [KW-1:0]    cnt_sum;
	logic [VW-1:0]    prod;
	logic             root_busy, mag_busy;
	logic [AW-1:0]    root_quot;
	logic [RW-1:0]    root_row, root_col;
	logic [YB-1:0]    mag_num, mag_quot;
	logic [31:0]      site_w;
	logic [31:0]      spin_w;

	assign site_w = 32'(in_data.site);
	assign spin_w = 32'(in_data.spin_value);

	always_comb begin
		r_next = (cur_row_q == RW'(SIDE - 1)) ? '0 : cur_row_q + 1'b1;
		r_prev = (cur_row_q == '0) ? RW'(SIDE - 1) : cur_row_q - 1'b1;
		c_next = (cur_col_q == RW'(SIDE - 1)) ? '0 : cur_col_q + 1'b1;
		c_prev = (cur_col_q == '0) ? RW'(SIDE - 1) : cur_col_q - 1'b1;
		nrow   = cur_row_q;
		ncol   = cur_col_q;
		case (k_q)
			NB_ROW_NEXT: nrow = r_next;
			NB_ROW_PREV: nrow = r_prev;
			NB_COL_NEXT: ncol = c_next;
			NB_COL_PREV: ncol = c_prev;
			default: nrow = cur_row_q;
		endcase
	end

	assign nb_addr  = AW'(32'(nrow) * SIDE + 32'(ncol));
	assign top_m1   = top_q - 1'b1;
	assign rng_next = xorshift32(rng_q);
	assign nb_match = spin_rdata_q == old_q;
	assign nb_join  = cmd.nb_check && nb_match && (rng_next < thresh_q) && (top_q < KW'(N));
	assign upd_en   = cmd.wr_site || nb_join;

	// spin store
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			spin_mem[clr_q] <= '0;
		end else if (cmd.wr_site) begin
			spin_mem[site_q] <= nw_q;
		end else if (nb_join) begin
			spin_mem[nb_addr] <= nw_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_site) begin
			spin_rdata_q <= spin_mem[site_q];
		end else if (cmd.rd_nb) begin
			spin_rdata_q <= spin_mem[nb_addr];
		end
	end

	// site stack
	always_ff @(posedge clk) begin
		if (cmd.push_root) begin
			stack_mem[top_q[AW-1:0]] <= {root_row, root_col};
		end else if (nb_join) begin
			stack_mem[top_q[AW-1:0]] <= {nrow, ncol};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			stack_rdata_q <= stack_mem[top_m1[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			ok_q        <= 1'b0;
			func_q      <= 1'b0;
			status_q    <= 1'b0;
			flipped_q   <= '0;
			top_q       <= '0;
			k_q         <= NB_ROW_NEXT;
			thresh_q    <= THRESH_RESET;
			rng_q       <= SEED_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < STATES; i++) begin
				cnt_q[i] <= (i == 0) ? KW'(N) : '0;
			end
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.in_take) begin
				ok_q      <= (site_w < N) && (spin_w < STATES);
				func_q    <= in_data.func;
				status_q  <= 1'b0;
				flipped_q <= '0;
			end
			if (cmd.set_same) begin
				status_q <= 1'b1;
			end
			if (cmd.push_root) begin
				top_q     <= KW'(1);
				flipped_q <= KW'(1);
			end else if (cmd.pop) begin
				top_q <= top_m1;
			end else if (nb_join) begin
				top_q     <= top_q + 1'b1;
				flipped_q <= flipped_q + 1'b1;
			end
			if (cmd.cur_take) begin
				k_q <= NB_ROW_NEXT;
			end else if (cmd.nb_check) begin
				k_q <= nb_dir_t'(k_q + 1'b1);
			end
			if (wr_en && wr_index == REG_ADD_THRESHOLD) begin
				thresh_q <= wr_data;
			end
			if (wr_en && wr_index == REG_RNG_SEED) begin
				rng_q <= (wr_data != '0) ? wr_data : 32'd1;
			end else if (cmd.nb_check && nb_match) begin
				rng_q <= rng_next;
			end
			if (upd_en) begin
				for (int i = 0; i < STATES; i++) begin
					cnt_q[i] <= cnt_q[i]
						- KW'((SW'(i) == spin_rdata_q) && (cnt_q[i] != '0))
						+ KW'(SW'(i) == nw_q);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			site_q <= AW'(site_w);
			nw_q   <= SW'(spin_w);
		end
		if (cmd.wr_site) begin
			old_q <= spin_rdata_q;
		end
		if (cmd.cur_take) begin
			cur_row_q <= stack_rdata_q[2*RW-1:RW];
			cur_col_q <= stack_rdata_q[RW-1:0];
		end
		if (cmd.max_take) begin
			largest_q <= largest_d;
		end
		if (cmd.out_load) begin
			out_q.cluster_size  <= 15'(flipped_q);
			out_q.largest_count <= 15'(largest_q);
			out_q.magnetization <= mag_quot[16:0];
			out_q.status        <= status_q;
		end
	end

	always_comb begin
		largest_d = '0;
		cnt_sum   = '0;
		for (int i = 0; i < STATES; i++) begin
			if (cnt_q[i] > largest_d) begin
				largest_d = cnt_q[i];
			end
			cnt_sum = cnt_sum + cnt_q[i];
		end
	end

	// root row and column split
	assign root_row = RW'(root_quot);
	assign root_col = RW'(site_q - AW'(32'(root_row) * SIDE));

	pwc_div #(
		.NW  (AW),
		.DEN (SIDE)
	) u_root_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_site),
		.num    (site_q),
		.busy   (root_busy),
		.quot   (root_quot)
	);

	// order parameter
	assign prod    = VW'(32'(largest_q) * STATES);
	assign mag_num = (prod > VW'(N)) ? {XB'(prod - VW'(N)), 16'b0} : '0;

	pwc_div #(
		.NW  (YB),
		.DEN (DEN)
	) u_mag_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_mag),
		.num    (mag_num),
		.busy   (mag_busy),
		.quot   (mag_quot)
	);

	always_comb begin
		stat.clr_last    = clr_q == AW'(N - 1);
		stat.in_ok       = ok_q;
		stat.func        = func_q;
		stat.same        = spin_rdata_q == nw_q;
		stat.div_busy    = root_busy || mag_busy;
		stat.stack_empty = top_q == '0;
		stat.k_last      = k_q == NB_COL_PREV;
		stat.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_counts_total: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_sum == KW'(N))
		else $error("state counts do not cover the lattice");
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= KW'(N))
		else $error("stack overflow");
	a_flip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nb_join |=> flipped_q == $past(flipped_q) + 1'b1)
		else $error("flip count not advanced on join");
`endif

endmodule

// File: hdl/potts_wolff_cluster_update_top.sv
// ----------------------------------------------------------------------------
// potts_wolff_cluster_update_top
// potts lattice with wolff cluster flips, one result per input transaction
//
// channel  signals                       direction
// in       in_valid, in_ready, in_data   host to block
// out      out_valid, out_ready, out_data block to host
// config   wr_en, wr_index, wr_data      host to block, no handshake
//
// after reset a clearing pass over all SIDE*SIDE sites zeroes the spin store;
// no input transaction is taken until it ends
// a load or rejected item gives a valid result after the largest-count capture
// and the order-parameter reciprocal multiply
// a cluster step adds the root split, push and final pop, then for each
// flipped site a pop, fetch and four neighbor read and check pairs
// a pending result in the output register does not stop the next transaction from being taken; its result waits
// until the register is free
module potts_wolff_cluster_update_top #(
	parameter int unsigned SIDE   = pwc_pkg::SIDE_DEFAULT,
	parameter int unsigned STATES = pwc_pkg::STATES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pwc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output pwc_pkg::out_t out_data,
	input  logic          wr_en,
	input  logic          wr_index,
	input  logic [31:0]   wr_data
);
	import pwc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pwc_datapath #(
		.SIDE   (SIDE),
		.STATES (STATES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
